// ===== rtl/core/rspg_pkg.sv =====
// Shared types, constants and color wheel helpers for the rainbow strip
// pattern generator. No dependencies.
package rspg_pkg;

    localparam int HUE_W   = 9;
    localparam int LEVEL_W = 15;
    localparam int IDX_W   = 6;
    localparam int CHAN_W  = 8;

    localparam logic [HUE_W-1:0]   HUE_FULL  = 9'd360;
    localparam logic [LEVEL_W-1:0] LEVEL_ONE = 15'd15360;
    localparam logic [8:0]         UNIT_256  = 9'd256;

    // Per-channel hue shift on the wheel
    localparam logic [HUE_W-1:0] SHIFT_CH0 = 9'd0;
    localparam logic [HUE_W-1:0] SHIFT_CH1 = 9'd120;
    localparam logic [HUE_W-1:0] SHIFT_CH2 = 9'd240;

    // Configuration register indexes
    localparam logic [2:0] CFG_SATURATION     = 3'd0;
    localparam logic [2:0] CFG_BRIGHTNESS     = 3'd1;
    localparam logic [2:0] CFG_FRAME_HUE_STEP = 3'd2;
    localparam logic [2:0] CFG_PIXEL_HUE_STEP = 3'd3;
    localparam logic [2:0] CFG_TURN_PIXEL     = 3'd4;

    // Pixel bookkeeping that rides alongside the datapath
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic             last;
    } pix_meta_t;

    // Channel level over 15360; h below 360, sat at most 256
    function automatic logic [LEVEL_W-1:0] wheel_level(
        input logic [HUE_W-1:0] h,
        input logic [8:0]       sat
    );
        logic [8:0]         floor_d;
        logic [LEVEL_W-1:0] lvl;
        floor_d = UNIT_256 - sat;
        if (h < 9'd120)
            lvl = LEVEL_ONE;
        else if (h < 9'd180)
            lvl = {1'b0, 6'(9'd180 - h), 8'd0};
        else if (h < 9'd300)
            lvl = 15'(floor_d) * 15'd60;
        else
            lvl = {1'b0, 6'(h - 9'd300), 8'd0};
        return lvl;
    endfunction

endpackage

// ===== rtl/core/rspg_channel.sv =====
// One color channel: wheel lookup stage, then brightness scaling stage.
// Depends on rspg_pkg.
module rspg_channel
    import rspg_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [HUE_W-1:0]  hue,
    input  logic [HUE_W-1:0]  shift,
    input  logic [8:0]        sat,
    input  logic [8:0]        bri,
    output logic [CHAN_W-1:0] value
);

    logic [HUE_W:0]      h_sum;
    logic [HUE_W-1:0]    h_wrap;
    logic [LEVEL_W-1:0]  level_reg;
    logic [23:0]         prod;
    logic [28:0]         scaled;
    logic [CHAN_W-1:0]   value_reg;

    // Shift hue onto this channel, wrap at 360
    always_comb
    begin
        h_sum  = {1'b0, hue} + {1'b0, shift};
        h_wrap = (h_sum >= {1'b0, HUE_FULL}) ? HUE_W'(h_sum - {1'b0, HUE_FULL})
                                             : h_sum[HUE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            level_reg <= wheel_level(h_wrap, sat);
        end
    end

    // 255 / 15360 / 256 reduces to 17 / 2^18, exact floor
    always_comb
    begin
        prod   = 24'(level_reg) * 24'(bri);
        scaled = {1'b0, prod, 4'd0} + 29'(prod);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg <= scaled[25:18];
        end
    end

    assign value = value_reg;

endmodule

// ===== rtl/core/rainbow_strip_pattern_generator.sv =====
// Rainbow strip pattern generator: each frame request (advance flag in
// s_axis_tdata[0]) produces NUM_PIXELS RGB pixels, one per cycle while
// the output does not stall, the last one marked by m_axis_tlast. Once a
// request is accepted the frame is active, and each pixel passes the hue1,
// level and value registers to the output. The next request is taken in
// the cycle the current frame's last pixel enters the pipeline, so frames
// stream without gaps. Output backpressure stalls the whole three-stage
// pipeline. Configuration writes are always accepted and should be made
// while no frame is in flight. Depends on rspg_pkg and rspg_channel.
module rainbow_strip_pattern_generator
    import rspg_pkg::*;
#(
    parameter int NUM_PIXELS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    // frame request
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] advance, [7:1] zero
    // pixel stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [5:0] pixel_index, [13:6] red,
                                        // [21:14] green, [29:22] blue, [31:30] zero
    output logic        m_axis_tlast,   // last_pixel
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PIXELS - 1);

    // Configuration registers
    logic [8:0]       saturation_reg;
    logic [8:0]       brightness_reg;
    logic [8:0]       frame_hue_step_reg;
    logic [8:0]       pixel_hue_step_reg;
    logic [IDX_W-1:0] turn_pixel_reg;

    // Frame state
    logic             active_reg, active_next;
    logic [HUE_W-1:0] base_hue_reg, base_hue_next;
    logic [HUE_W-1:0] offset_reg, offset_next;
    logic [IDX_W-1:0] count_reg, count_next;

    // Pipeline
    pix_meta_t        meta1_reg, meta2_reg, meta3_reg;
    logic [HUE_W-1:0] hue1_reg;

    logic             adv;
    logic             emit;
    logic             at_last;
    logic             s_accept;
    logic [8:0]       sat_c, bri_c, step_c;
    logic [HUE_W:0]   pix_sum, base_sum, off_inc;
    logic [HUE_W-1:0] hue_pix;
    logic [7:0]       red, green, blue;

    assign cfg_ready = 1'b1;

    // Configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            saturation_reg     <= 9'd256;
            brightness_reg     <= 9'd256;
            frame_hue_step_reg <= 9'd3;
            pixel_hue_step_reg <= 9'd30;
            turn_pixel_reg     <= 6'd22;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SATURATION:     saturation_reg     <= cfg_data;
                CFG_BRIGHTNESS:     brightness_reg     <= cfg_data;
                CFG_FRAME_HUE_STEP: frame_hue_step_reg <= cfg_data;
                CFG_PIXEL_HUE_STEP: pixel_hue_step_reg <= cfg_data;
                CFG_TURN_PIXEL:     turn_pixel_reg     <= cfg_data[IDX_W-1:0];
                default:            ;
            endcase
        end
    end

    // Clamped and reduced settings
    always_comb
    begin
        sat_c  = (saturation_reg > UNIT_256) ? UNIT_256 : saturation_reg;
        bri_c  = (brightness_reg > UNIT_256) ? UNIT_256 : brightness_reg;
        step_c = (pixel_hue_step_reg >= HUE_FULL) ? 9'(pixel_hue_step_reg - HUE_FULL)
                                                  : pixel_hue_step_reg;
    end

    // Handshake and pipeline advance
    assign adv           = !meta3_reg.valid || m_axis_tready;
    assign emit          = active_reg && adv;
    assign at_last       = (count_reg == LAST_IDX);
    assign s_axis_tready = !active_reg || (adv && at_last);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Frame sequencing: hue of current pixel and offset walk
    always_comb
    begin
        pix_sum  = {1'b0, base_hue_reg} + {1'b0, offset_reg};
        hue_pix  = (pix_sum >= {1'b0, HUE_FULL}) ? HUE_W'(pix_sum - {1'b0, HUE_FULL})
                                                 : pix_sum[HUE_W-1:0];
        base_sum = {1'b0, base_hue_reg} + {1'b0, frame_hue_step_reg};
        off_inc  = {1'b0, offset_reg} + {1'b0, step_c};

        active_next   = active_reg;
        base_hue_next = base_hue_reg;
        offset_next   = offset_reg;
        count_next    = count_reg;

        if (emit)
        begin
            count_next = count_reg + IDX_W'(1);
            if (count_reg > turn_pixel_reg)
            begin
                offset_next = (offset_reg >= step_c) ? 9'(offset_reg - step_c)
                                                     : 9'(offset_reg + HUE_FULL - step_c);
            end
            else
            begin
                offset_next = (off_inc >= {1'b0, HUE_FULL}) ? HUE_W'(off_inc - {1'b0, HUE_FULL})
                                                            : off_inc[HUE_W-1:0];
            end
            if (at_last)
            begin
                active_next = 1'b0;
            end
        end

        if (s_accept)
        begin
            active_next = 1'b1;
            offset_next = '0;
            count_next  = '0;
            if (s_axis_tdata[0])
            begin
                base_hue_next = (base_sum >= {1'b0, HUE_FULL}) ? '0 : base_sum[HUE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            base_hue_reg <= '0;
            offset_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            active_reg   <= active_next;
            base_hue_reg <= base_hue_next;
            offset_reg   <= offset_next;
            count_reg    <= count_next;
        end
    end

    // Pixel bookkeeping through the three stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta1_reg <= '0;
            meta2_reg <= '0;
            meta3_reg <= '0;
        end
        else if (adv)
        begin
            meta1_reg <= '{valid: emit, idx: count_reg, last: at_last};
            meta2_reg <= meta1_reg;
            meta3_reg <= meta2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hue1_reg <= hue_pix;
        end
    end

    // Channels: red on 1, green on 0, blue on 2
    rspg_channel u_red
    (
        .clk   (clk),
        .en    (adv),
        .hue   (hue1_reg),
        .shift (SHIFT_CH1),
        .sat   (sat_c),
        .bri   (bri_c),
        .value (red)
    );

    rspg_channel u_green
    (
        .clk   (clk),
        .en    (adv),
        .hue   (hue1_reg),
        .shift (SHIFT_CH0),
        .sat   (sat_c),
        .bri   (bri_c),
        .value (green)
    );

    rspg_channel u_blue
    (
        .clk   (clk),
        .en    (adv),
        .hue   (hue1_reg),
        .shift (SHIFT_CH2),
        .sat   (sat_c),
        .bri   (bri_c),
        .value (blue)
    );

    assign m_axis_tvalid = meta3_reg.valid;
    assign m_axis_tlast  = meta3_reg.last;
    assign m_axis_tdata  = {2'b00, blue, green, red, meta3_reg.idx};

    // Checks
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[5:0] == LAST_IDX))
        else $error("last pixel flag on wrong index");

    a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
        base_hue_reg < HUE_FULL)
        else $error("base hue out of range");

    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        offset_reg < HUE_FULL)
        else $error("hue offset out of range");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        meta1_reg.valid |-> (hue1_reg < HUE_FULL))
        else $error("pixel hue out of range");

endmodule
